// ----- rtl/core/vsa_pkg.sv -----
// Shared types and constants for the voice steal allocator.
// No dependencies; imported by every module of the block.
package vsa_pkg;

  // Default number of dynamic voices
  localparam int VOICES_DEF = 8;

  // Remaining-time ceiling; a voice is stolen only strictly below it
  localparam logic [31:0] LIFE_START = 32'h7fff_ffff;

  // Slot pattern that matches any slot on start
  localparam logic [3:0] SLOT_ANY = 4'hf;

  // Command codes
  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_WRITE,
    ST_DONE
  } state_t;

  // One request transfer
  typedef struct packed {
    logic [1:0]        cmd;
    logic [15:0]       entity;
    logic signed [3:0] ent_slot;
    logic [23:0]       sound_length;
    logic              audible;
    logic [29:0]       now;
  } in_item_t;

  // One result transfer
  typedef struct packed {
    logic [2:0] voice_index;
    logic       found;
    logic       stole_active;
  } out_item_t;

  // One voice table entry
  typedef struct packed {
    logic [15:0] entity;
    logic [3:0]  slot;
    logic [31:0] end_time;
    logic        active;
  } voice_t;

  // Scan control from the sequencer to the pick unit
  typedef struct packed {
    logic init;
    logic eval;
  } scan_ctl_t;

  // Pick status back to the sequencer
  typedef struct packed {
    logic hit;
    logic active;
  } pick_t;

endpackage

// ----- rtl/core/vsa_voice_mem.sv -----
// Voice table: synchronous memory with a registered read port and per-entry valid bits.
// Depends on vsa_pkg (voice_t).
module vsa_voice_mem #(
  parameter int VOICES = vsa_pkg::VOICES_DEF,
  parameter int IDX_W  = $clog2(VOICES)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                clear_all,
  input  logic [IDX_W-1:0]    rd_addr,
  output vsa_pkg::voice_t     rd_data,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_addr,
  input  vsa_pkg::voice_t     wr_data
);
  import vsa_pkg::*;

  voice_t              voice_mem_r [VOICES];
  logic [VOICES-1:0]   valid_r;
  logic [VOICES-1:0]   valid_nxt;
  voice_t              rd_raw_r;
  logic                rd_vld_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      voice_mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_raw_r <= voice_mem_r[rd_addr];
    rd_vld_r <= valid_r[rd_addr];
  end

  // Drop valid on clear-all, raise it on a write
  always_comb begin
    valid_nxt = valid_r;
    if (clear_all) begin
      valid_nxt = '0;
    end else if (wr_en) begin
      valid_nxt[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Entries never written since reset or clear read as zero
  assign rd_data = rd_vld_r ? rd_raw_r : '0;

endmodule

// ----- rtl/core/vsa_pick.sv -----
// Pick unit: evaluates one voice entry per cycle and keeps the reuse, steal
// and stop candidates. Depends on vsa_pkg.
module vsa_pick #(
  parameter int VOICES = vsa_pkg::VOICES_DEF,
  parameter int IDX_W  = $clog2(VOICES)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  vsa_pkg::scan_ctl_t   ctl,
  input  vsa_pkg::in_item_t    req,
  input  logic [15:0]          view_entity,
  input  vsa_pkg::voice_t      entry,
  input  logic [IDX_W-1:0]     entry_idx,
  output vsa_pkg::pick_t       pick,
  output logic [IDX_W-1:0]     pick_idx
);
  import vsa_pkg::*;

  logic              reuse_hit_r, reuse_hit_nxt;
  logic [IDX_W-1:0]  reuse_idx_r, reuse_idx_nxt;
  logic              reuse_act_r, reuse_act_nxt;
  logic              steal_hit_r, steal_hit_nxt;
  logic [IDX_W-1:0]  steal_idx_r, steal_idx_nxt;
  logic              steal_act_r, steal_act_nxt;
  logic [31:0]       life_r, life_nxt;
  logic              stop_hit_r, stop_hit_nxt;
  logic [IDX_W-1:0]  stop_idx_r, stop_idx_nxt;

  logic [3:0]        req_slot;
  logic              reuse_now;
  logic              protect_now;
  logic [31:0]       left;
  logic              better;
  logic              stop_now;

  // Per-entry match and remaining-time compare
  always_comb begin
    req_slot    = req.ent_slot;
    reuse_now   = (req_slot != 4'd0) && (entry.entity == req.entity) &&
                  ((entry.slot == req_slot) || (req_slot == SLOT_ANY));
    protect_now = (entry.entity == view_entity) && (req.entity != view_entity) &&
                  entry.active;
    left        = entry.end_time - {2'b00, req.now};
    better      = $signed(left) < $signed(life_r);
    stop_now    = (entry.entity == req.entity) && (entry.slot == req_slot);
  end

  // Advance candidates; the first reuse and the first stop match hold
  always_comb begin
    reuse_hit_nxt = reuse_hit_r;
    reuse_idx_nxt = reuse_idx_r;
    reuse_act_nxt = reuse_act_r;
    steal_hit_nxt = steal_hit_r;
    steal_idx_nxt = steal_idx_r;
    steal_act_nxt = steal_act_r;
    life_nxt      = life_r;
    stop_hit_nxt  = stop_hit_r;
    stop_idx_nxt  = stop_idx_r;
    if (ctl.init) begin
      reuse_hit_nxt = 1'b0;
      reuse_idx_nxt = '0;
      reuse_act_nxt = 1'b0;
      steal_hit_nxt = 1'b0;
      steal_idx_nxt = '0;
      steal_act_nxt = 1'b0;
      life_nxt      = LIFE_START;
      stop_hit_nxt  = 1'b0;
      stop_idx_nxt  = '0;
    end else if (ctl.eval) begin
      if (!reuse_hit_r && reuse_now) begin
        reuse_hit_nxt = 1'b1;
        reuse_idx_nxt = entry_idx;
        reuse_act_nxt = entry.active;
      end else if (!protect_now && better) begin
        steal_hit_nxt = 1'b1;
        steal_idx_nxt = entry_idx;
        steal_act_nxt = entry.active;
        life_nxt      = left;
      end
      if (!stop_hit_r && stop_now) begin
        stop_hit_nxt = 1'b1;
        stop_idx_nxt = entry_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reuse_hit_r <= 1'b0;
      steal_hit_r <= 1'b0;
      stop_hit_r  <= 1'b0;
    end else begin
      reuse_hit_r <= reuse_hit_nxt;
      steal_hit_r <= steal_hit_nxt;
      stop_hit_r  <= stop_hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    reuse_idx_r <= reuse_idx_nxt;
    reuse_act_r <= reuse_act_nxt;
    steal_idx_r <= steal_idx_nxt;
    steal_act_r <= steal_act_nxt;
    life_r      <= life_nxt;
    stop_idx_r  <= stop_idx_nxt;
  end

  // Select the candidate that the command asks for
  always_comb begin
    pick.hit    = 1'b0;
    pick.active = 1'b0;
    pick_idx    = '0;
    case (cmd_t'(req.cmd))
      CMD_START: begin
        if (reuse_hit_r) begin
          pick.hit    = 1'b1;
          pick.active = reuse_act_r;
          pick_idx    = reuse_idx_r;
        end else if (steal_hit_r) begin
          pick.hit    = 1'b1;
          pick.active = steal_act_r;
          pick_idx    = steal_idx_r;
        end
      end
      CMD_STOP: begin
        if (stop_hit_r) begin
          pick.hit = 1'b1;
          pick_idx = stop_idx_r;
        end
      end
      default: begin
        pick.hit = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/core/voice_steal_allocator.sv -----
// Voice steal allocator: start, stop and clear-all over a table of dynamic voices.
// Start and stop scan the memory one entry per cycle (ST_SCAN, ST_LAST, ST_WRITE, ST_DONE);
// clear and no-op go straight to ST_DONE. Busy holds through the strobe cycle, so a new
// request is accepted only after the result of the last one. Reset (synchronous, rst_n low)
// empties the table through per-entry valid bits and clears view_entity; the result strobe
// cannot be stalled.
module voice_steal_allocator #(
  parameter int VOICES = vsa_pkg::VOICES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  vsa_pkg::in_item_t   in_item,
  output logic                out_strobe,
  output vsa_pkg::out_item_t  out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);
  import vsa_pkg::*;

  localparam int IDX_W = $clog2(VOICES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VOICES - 1);

  state_t            state_r, state_nxt;
  in_item_t          req_r;
  logic [15:0]       view_entity_r;
  logic [IDX_W-1:0]  ptr_r, ptr_nxt;
  logic              eval_vld_r;
  logic [IDX_W-1:0]  eval_idx_r;
  logic              accept;
  logic              clear_all;
  scan_ctl_t         ctl;
  voice_t            rd_data;
  voice_t            wr_data;
  logic              wr_en;
  pick_t             pick;
  logic [IDX_W-1:0]  pick_idx;
  logic [31:0]       end_sum;

  assign accept    = start && !busy;
  assign clear_all = accept && (cmd_t'(in_item.cmd) == CMD_CLEAR);
  assign cfg_ready = 1'b1;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_entity_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      view_entity_r <= cfg_data;
    end
  end

  // Hold the request for the whole scan
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_item;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_t'(in_item.cmd) inside {CMD_START, CMD_STOP}) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (ptr_r == LAST_IDX) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST:  state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    busy       = (state_r != ST_IDLE);
    out_strobe = (state_r == ST_DONE);
    wr_en      = (state_r == ST_WRITE) && pick.hit;
    ctl.init   = accept;
    ctl.eval   = eval_vld_r;
    ptr_nxt    = ptr_r;
    if (accept) begin
      ptr_nxt = '0;
    end else if (state_r == ST_SCAN) begin
      ptr_nxt = ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      ptr_r      <= '0;
      eval_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ptr_r      <= ptr_nxt;
      eval_vld_r <= (state_r == ST_SCAN);
    end
  end

  // Track which entry the read data belongs to
  always_ff @(posedge clk) begin
    eval_idx_r <= ptr_r;
  end

  // Build the write-back entry; stop keeps entity and slot, which already match
  always_comb begin
    end_sum          = {2'b00, req_r.now} + {8'h00, req_r.sound_length};
    wr_data.entity   = req_r.entity;
    wr_data.slot     = req_r.ent_slot;
    wr_data.end_time = '0;
    wr_data.active   = 1'b0;
    if ((cmd_t'(req_r.cmd) == CMD_START) && req_r.audible) begin
      wr_data.end_time = end_sum;
      wr_data.active   = 1'b1;
    end
  end

  // Result fields come straight from the pick registers
  assign out_item.voice_index  = 3'(pick_idx);
  assign out_item.found        = pick.hit;
  assign out_item.stole_active = pick.active;

  vsa_voice_mem #(
    .VOICES (VOICES),
    .IDX_W  (IDX_W)
  ) u_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear_all (clear_all),
    .rd_addr   (ptr_r),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (pick_idx),
    .wr_data   (wr_data)
  );

  vsa_pick #(
    .VOICES (VOICES),
    .IDX_W  (IDX_W)
  ) u_pick (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .req         (req_r),
    .view_entity (view_entity_r),
    .entry       (rd_data),
    .entry_idx   (eval_idx_r),
    .pick        (pick),
    .pick_idx    (pick_idx)
  );

endmodule

// ----- test/voice_steal_allocator_tb.sv -----
// Self-checking testbench for voice_steal_allocator: directed and random requests
// checked against a behavioral voice table kept in the bench. Depends on vsa_pkg.
module voice_steal_allocator_tb;
  import vsa_pkg::*;

  localparam int VOICES = VOICES_DEF;
  // result latency of a scan plus margin, used before view writes and at the end
  localparam int SETTLE = VOICES + 6;

  typedef enum logic [1:0] {
    OP_ITEM,
    OP_VIEW,
    OP_DRAIN
  } op_kind_t;

  typedef struct {
    op_kind_t    kind;
    in_item_t    item;
    logic [15:0] view;
    int          gap;
  } req_op_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  in_item_t   in_item = '0;
  logic       out_strobe;
  out_item_t  out_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [15:0] cfg_data = '0;

  // stimulus feed and predicted results
  req_op_t    req_queue[$];
  out_item_t  predicted_grants[$];

  // behavioral copy of the voice table and the listener register
  voice_t      voice_tab [VOICES];
  logic [15:0] listener;

  // driver bookkeeping
  logic       start_nxt;
  logic       cfg_nxt;
  int         gap_left;
  int         idle_run;
  req_op_t    head_op;

  // generator state
  logic        burst = 1'b0;
  logic [29:0] t_now = '0;
  logic [19:0] started_keys[$];

  // run statistics
  int n_err = 0;
  int n_items = 0;
  int n_views = 0;
  int n_granted = 0;
  int n_stolen = 0;
  int n_stops = 0;
  int n_refused = 0;
  out_item_t want_res;

  voice_steal_allocator #(.VOICES(VOICES)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // 2 time unit clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predict one request and update the voice table copy.
  function automatic out_item_t allocate_voice(in_item_t req);
    out_item_t   res;
    int          pick;
    logic [31:0] life;
    logic [31:0] remain;
    logic [3:0]  slot;
    res = '0;
    pick = -1;
    life = LIFE_START;
    slot = req.ent_slot;
    case (cmd_t'(req.cmd))
      CMD_START: begin
        for (int i = 0; i < VOICES; i++) begin
          // same entity and a matching nonzero slot (or the any-slot pattern) reuses the voice outright
          if (slot != 4'd0 && voice_tab[i].entity == req.entity &&
              (voice_tab[i].slot == slot || slot == SLOT_ANY)) begin
            pick = i;
            break;
          end
          // protect the listener's live voices from other entities
          if (voice_tab[i].entity == listener && req.entity != listener &&
              voice_tab[i].active)
            continue;
          remain = voice_tab[i].end_time - {2'b00, req.now};
          if ($signed(remain) < $signed(life)) begin
            life = remain;
            pick = i;
          end
        end
        if (pick >= 0) begin
          res.voice_index = pick[2:0];
          res.found = 1'b1;
          res.stole_active = voice_tab[pick].active;
          voice_tab[pick].entity = req.entity;
          voice_tab[pick].slot = slot;
          voice_tab[pick].active = req.audible;
          voice_tab[pick].end_time = req.audible ?
              {2'b00, req.now} + {8'd0, req.sound_length} : 32'd0;
        end
      end
      CMD_STOP: begin
        for (int i = 0; i < VOICES; i++) begin
          if (voice_tab[i].entity == req.entity && voice_tab[i].slot == slot) begin
            voice_tab[i].end_time = '0;
            voice_tab[i].active = 1'b0;
            res.voice_index = i[2:0];
            res.found = 1'b1;
            break;
          end
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < VOICES; i++) voice_tab[i] = '0;
      end
      default: ;
    endcase
    return res;
  endfunction

  // Queue one request with the idle gap that follows it.
  task automatic push_req(cmd_t cmd, logic [15:0] ent, int slot, logic [23:0] len,
                          logic aud, logic [29:0] now);
    req_op_t op;
    int      r;
    op.kind = OP_ITEM;
    op.view = '0;
    op.item.cmd = cmd;
    op.item.entity = ent;
    op.item.ent_slot = 4'(slot);
    op.item.sound_length = len;
    op.item.audible = aud;
    op.item.now = now;
    // toggle between back-to-back stretches and gapped traffic
    if ($urandom_range(0, 99) == 0) burst = !burst;
    r = $urandom_range(0, 99);
    if (burst || r < 50) op.gap = 0;
    else if (r < 85) op.gap = $urandom_range(1, 3);
    else if (r < 97) op.gap = $urandom_range(4, 15);
    else op.gap = $urandom_range(30, 200);
    req_queue.push_back(op);
  endtask

  task automatic push_ctl(op_kind_t kind, logic [15:0] view);
    req_op_t op;
    op.kind = kind;
    op.item = '0;
    op.view = view;
    op.gap = 0;
    req_queue.push_back(op);
  endtask

  // Random traffic under one listener setting.
  task automatic random_phase(logic [15:0] view, int count);
    logic [15:0] pool [5];
    logic [15:0] ent;
    logic [23:0] len;
    logic [19:0] key;
    int          slot;
    int          r;
    int          drain_at;
    pool[0] = view;
    pool[1] = 16'h0000;
    pool[2] = 16'hffff;
    pool[3] = 16'($urandom());
    pool[4] = 16'($urandom());
    drain_at = $urandom_range(count / 4, 3 * count / 4);
    push_ctl(OP_VIEW, view);
    for (int n = 0; n < count; n++) begin
      if (n == drain_at) push_ctl(OP_DRAIN, '0);
      // advance painted time, with rare jumps anywhere
      if ($urandom_range(0, 99) < 3) t_now = 30'($urandom());
      else t_now = t_now + 30'($urandom_range(0, 8192));
      r = $urandom_range(0, 99);
      ent = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : pool[$urandom_range(0, 4)];
      r = $urandom_range(0, 99);
      slot = (r < 10) ? -1 : (r < 25) ? 0 : $urandom_range(1, 7);
      r = $urandom_range(0, 99);
      len = (r < 3) ? 24'($urandom()) : (r < 6) ? 24'd0 : 24'($urandom_range(0, 65535));
      r = $urandom_range(0, 99);
      if (r < 4) begin
        // flood the table with the listener's voices, then try to steal one
        for (int k = 0; k < VOICES; k++) begin
          push_req(CMD_START, view, k, 24'($urandom_range(40000, 16777215)), 1'b1,
                   t_now);
          n++;
        end
        push_req(CMD_START, pool[3] ^ 16'h0001, 3, len, 1'b1, t_now);
      end else if (r < 58) begin
        push_req(CMD_START, ent, slot, len, ($urandom_range(0, 99) < 85), t_now);
        started_keys.push_back({ent, 4'(slot)});
        if (started_keys.size() > 16) void'(started_keys.pop_front());
      end else if (r < 94) begin
        // stops mostly aim at a recently started owner
        if (started_keys.size() != 0 && $urandom_range(0, 99) < 65) begin
          key = started_keys[$urandom_range(0, started_keys.size() - 1)];
          push_req(CMD_STOP, key[19:4], $signed(key[3:0]), len, 1'($urandom()), t_now);
        end else begin
          push_req(CMD_STOP, ent, slot, len, 1'($urandom()), t_now);
        end
      end else if (r < 97) begin
        push_req(CMD_CLEAR, ent, slot, len, 1'($urandom()), t_now);
      end else begin
        push_req(CMD_NOP, ent, slot, len, 1'($urandom()), t_now);
      end
    end
  endtask

  // Driver: retire transfers of the ending cycle, then launch the next operation.
  always @(posedge clk) begin
    start_nxt = start;
    cfg_nxt = cfg_valid;
    if (!rst_n) begin
      start_nxt = 1'b0;
      cfg_nxt = 1'b0;
      gap_left = 0;
      idle_run = 0;
      listener = '0;
      for (int i = 0; i < VOICES; i++) voice_tab[i] = '0;
    end else begin
      if (start && !busy) begin
        want_res = allocate_voice(in_item);
        predicted_grants.push_back(want_res);
        if (cmd_t'(in_item.cmd) == CMD_START) begin
          if (want_res.found) n_granted++;
          else n_refused++;
          if (want_res.stole_active) n_stolen++;
        end
        if (cmd_t'(in_item.cmd) == CMD_STOP && want_res.found) n_stops++;
        start_nxt = 1'b0;
        n_items++;
      end
      if (cfg_valid && cfg_ready) begin
        listener = cfg_data;
        cfg_nxt = 1'b0;
        n_views++;
      end
      // count quiet cycles so a view write lands only on an idle block
      if (predicted_grants.size() == 0 && !busy && !start_nxt && !cfg_nxt) idle_run++;
      else idle_run = 0;
      if (!start_nxt && !cfg_nxt && req_queue.size() != 0) begin
        if (gap_left != 0) begin
          gap_left--;
        end else begin
          head_op = req_queue[0];
          case (head_op.kind)
            OP_ITEM: begin
              in_item <= head_op.item;
              start_nxt = 1'b1;
              gap_left = head_op.gap;
              void'(req_queue.pop_front());
            end
            OP_VIEW: begin
              if (idle_run > SETTLE) begin
                cfg_data <= head_op.view;
                cfg_nxt = 1'b1;
                void'(req_queue.pop_front());
              end
            end
            default: begin
              if (predicted_grants.size() == 0) void'(req_queue.pop_front());
            end
          endcase
        end
      end
    end
    start <= start_nxt;
    cfg_valid <= cfg_nxt;
  end

  // Monitor: compare every strobed result with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (predicted_grants.size() == 0) begin
        $error("unexpected result: voice_index %0d found %0b stole_active %0b",
               out_item.voice_index, out_item.found, out_item.stole_active);
        n_err++;
      end else begin
        want_res = predicted_grants.pop_front();
        if (out_item.voice_index !== want_res.voice_index) begin
          $error("voice_index: expected %0d, got %0d", want_res.voice_index,
                 out_item.voice_index);
          n_err++;
        end
        if (out_item.found !== want_res.found) begin
          $error("found: expected %0b, got %0b", want_res.found, out_item.found);
          n_err++;
        end
        if (out_item.stole_active !== want_res.stole_active) begin
          $error("stole_active: expected %0b, got %0b", want_res.stole_active,
                 out_item.stole_active);
          n_err++;
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, slot rules, protection, every command
    push_ctl(OP_VIEW, 16'h00a5);
    push_req(CMD_START, 16'hffff, 7, 24'hffffff, 1'b1, 30'h3fffffff);
    push_req(CMD_START, 16'h0000, 0, 24'h0, 1'b0, 30'h0);
    push_req(CMD_START, 16'hffff, 7, 24'h100, 1'b1, 30'h10);
    push_req(CMD_START, 16'hffff, -1, 24'h200, 1'b1, 30'h20);
    push_req(CMD_STOP, 16'hffff, 7, 24'h0, 1'b0, 30'h30);
    push_req(CMD_STOP, 16'hffff, -1, 24'h0, 1'b0, 30'h30);
    push_req(CMD_STOP, 16'h1234, 3, 24'h0, 1'b0, 30'h30);
    push_req(CMD_NOP, 16'h5a5a, 2, 24'h123456, 1'b1, 30'h2aaaaaaa);
    push_req(CMD_CLEAR, 16'ha5a5, 5, 24'h654321, 1'b1, 30'h15555555);
    for (int k = 1; k <= VOICES; k++)
      push_req(CMD_START, 16'h00a5, k % VOICES, 24'h10000, 1'b1, 30'h1000);
    push_req(CMD_START, 16'h0042, 2, 24'h10, 1'b1, 30'h1100);
    push_req(CMD_START, 16'h00a5, 3, 24'h20, 1'b1, 30'h1200);
    push_req(CMD_START, 16'h00a5, 0, 24'h30, 1'b1, 30'h1300);
    push_req(CMD_STOP, 16'h00a5, 0, 24'h0, 1'b0, 30'h1400);
    push_req(CMD_START, 16'h0042, 5, 24'h0, 1'b1, 30'h2000);
    push_req(CMD_CLEAR, 16'h0000, 0, 24'h0, 1'b0, 30'h2100);

    // random phases over several listener settings, extremes first
    random_phase(16'h0000, 206);
    random_phase(16'hffff, 206);
    random_phase(16'($urandom()), 206);
    random_phase(16'h8000, 206);
    random_phase(16'($urandom()), 206);

    while (req_queue.size() != 0 || start || cfg_valid || predicted_grants.size() != 0)
      @(posedge clk);
    repeat (SETTLE + 4) @(posedge clk);

    $display("tb: %0d requests over %0d listener settings; %0d starts granted, %0d refused",
             n_items, n_views, n_granted, n_refused);
    $display("tb: %0d active voices stolen, %0d stops matched", n_stolen, n_stops);
    if (n_err == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/vsa_pkg.sv
rtl/core/vsa_voice_mem.sv
rtl/core/vsa_pick.sv
rtl/core/voice_steal_allocator.sv
test/voice_steal_allocator_tb.sv
